// ----- hdl/pfdc_pkg.sv -----
// shared types, constants and helper functions of the playfair digraph cipher
`timescale 1ns / 1ps

package pfdc_pkg;

    localparam int LetterW = 5;
    localparam int CoordW  = 3;
    localparam int Letters = 26;
    localparam int Cells   = 25;

    localparam logic [LetterW-1:0] LETTER_I = 5'd8;
    localparam logic [LetterW-1:0] LETTER_J = 5'd9;
    localparam logic [LetterW-1:0] LETTER_Z = 5'd25;

    // last row or column index of the square, and the row count marking a full square
    localparam logic [CoordW-1:0] SIDE_LAST = 3'd4;
    localparam logic [CoordW-1:0] SIDE      = 3'd5;

    typedef enum logic [1:0] {
        KIND_KEY_LETTER = 2'd0,
        KIND_KEY_END    = 2'd1,
        KIND_ENCRYPT    = 2'd2,
        KIND_DECRYPT    = 2'd3
    } kind_t;

    typedef struct packed {
        logic key_letter;   // place a key letter at the accept edge
        logic fill_start;   // rewind the fill letter counter
        logic fill_step;    // one letter of the key end fill
        logic pair_look;    // read both letter positions at the accept edge
        logic cell_load;    // read both square cells into the result register
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;    // current fill step is the final one
    } dp_status_t;

    // +1 or -1 modulo 5
    function automatic logic [CoordW-1:0] step_mod5(input logic [CoordW-1:0] v,
                                                    input logic back);
        logic [CoordW-1:0] r;
        if (back) begin
            r = (v == '0) ? SIDE_LAST : v - 3'd1;
        end else begin
            r = (v >= SIDE_LAST) ? '0 : v + 3'd1;
        end
        return r;
    endfunction

    // row * 5 + col
    function automatic logic [LetterW-1:0] cell_index(input logic [CoordW-1:0] row,
                                                      input logic [CoordW-1:0] col);
        logic [LetterW-1:0] r5;
        r5 = {row, 2'b00} + {2'b00, row};
        return r5 + {2'b00, col};
    endfunction

endpackage

// ----- hdl/pfdc_ctrl.sv -----
// controller state machine: handshakes, key end fill sequencing and result slot
`timescale 1ns / 1ps

module pfdc_ctrl
    import pfdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  kind_t       s_kind,
    output logic        m_tvalid,
    input  logic        m_tready,
    output dp_cmd_t     cmd,
    input  dp_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_CELL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        KIND_KEY_LETTER: cmd.key_letter = 1'b1;
                        KIND_KEY_END: begin
                            cmd.fill_start = 1'b1;
                            state_next     = ST_FILL;
                        end
                        KIND_ENCRYPT, KIND_DECRYPT: begin
                            cmd.pair_look = 1'b1;
                            state_next    = ST_CELL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CELL: begin
                if (slot_free) begin
                    cmd.cell_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/pfdc_datapath.sv -----
// datapath: square and position memories, key bookkeeping, pair transform
`timescale 1ns / 1ps

module pfdc_datapath
    import pfdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  kind_t              s_kind,
    input  logic [LetterW-1:0] s_letter_a,
    input  logic [LetterW-1:0] s_letter_b,
    output logic [LetterW-1:0] first_letter,
    output logic [LetterW-1:0] second_letter,
    output logic               not_ready
);

    logic [LetterW-1:0]  sq_mem  [0:Cells-1];
    logic [2*CoordW-1:0] pos_mem [0:Letters-1];

    logic [Letters-1:0]  used_reg, used_next;
    logic [CoordW-1:0]   row_reg, row_next;
    logic [CoordW-1:0]   col_reg, col_next;
    logic                ready_reg, ready_next;
    logic [LetterW-1:0]  fill_reg, fill_next;

    logic [2*CoordW-1:0] pa_reg, pb_reg;
    logic                back_reg;
    logic [LetterW-1:0]  first_reg, second_reg;
    logic                nr_reg;

    logic [Letters-1:0]  base_used;
    logic [CoordW-1:0]   base_row, base_col;
    logic [LetterW-1:0]  key_idx;
    logic                key_ok, fill_ok, full;
    logic                wr_en;
    logic [LetterW-1:0]  wr_letter;
    logic [CoordW-1:0]   wr_row, wr_col;
    logic [LetterW-1:0]  look_a, look_b;
    logic [CoordW-1:0]   ra, ca, rb, cb;
    logic [CoordW-1:0]   ra_o, ca_o, rb_o, cb_o;

    // a key letter after a finished key starts from an empty square
    assign base_used = ready_reg ? '0 : used_reg;
    assign base_row  = ready_reg ? '0 : row_reg;
    assign base_col  = ready_reg ? '0 : col_reg;
    assign key_idx   = (s_letter_a > LETTER_Z) ? LETTER_Z : s_letter_a;
    assign full      = (row_reg == SIDE);

    assign key_ok  = (s_letter_a <= LETTER_Z) && (s_letter_a != LETTER_J)
                     && !base_used[key_idx] && (base_row != SIDE);
    assign fill_ok = !full && (fill_reg != LETTER_J) && !used_reg[fill_reg];

    assign wr_en     = (cmd.key_letter && key_ok) || (cmd.fill_step && fill_ok);
    assign wr_letter = cmd.key_letter ? s_letter_a : fill_reg;
    assign wr_row    = cmd.key_letter ? base_row : row_reg;
    assign wr_col    = cmd.key_letter ? base_col : col_reg;

    assign status.fill_last = (fill_reg == LETTER_Z) || full;

    always_comb begin
        used_next  = cmd.key_letter ? base_used : used_reg;
        row_next   = cmd.key_letter ? base_row : row_reg;
        col_next   = cmd.key_letter ? base_col : col_reg;
        ready_next = ready_reg;
        fill_next  = fill_reg;
        if (wr_en) begin
            used_next = used_next | (Letters'(1) << wr_letter);
            if (wr_col == SIDE_LAST) begin
                col_next = '0;
                row_next = wr_row + 3'd1;
            end else begin
                col_next = wr_col + 3'd1;
                row_next = wr_row;
            end
        end
        if (cmd.key_letter) begin
            ready_next = 1'b0;
        end
        if (cmd.fill_start) begin
            fill_next = '0;
        end else if (cmd.fill_step) begin
            fill_next = fill_reg + 5'd1;
            if (status.fill_last) begin
                ready_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            ready_reg <= 1'b0;
            fill_reg  <= '0;
        end else begin
            used_reg  <= used_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ready_reg <= ready_next;
            fill_reg  <= fill_next;
        end
    end

    // memory writes: cell gets the letter, letter gets its row and column
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sq_mem[cell_index(wr_row, wr_col)] <= wr_letter;
            pos_mem[wr_letter]                 <= {wr_row, wr_col};
        end
    end

    // pair letters: saturate to z, j looks up the position of i
    always_comb begin
        look_a = (s_letter_a > LETTER_Z) ? LETTER_Z : s_letter_a;
        look_b = (s_letter_b > LETTER_Z) ? LETTER_Z : s_letter_b;
        if (look_a == LETTER_J) look_a = LETTER_I;
        if (look_b == LETTER_J) look_b = LETTER_I;
    end

    always_ff @(posedge aclk) begin
        if (cmd.pair_look) begin
            pa_reg   <= pos_mem[look_a];
            pb_reg   <= pos_mem[look_b];
            back_reg <= (s_kind == KIND_DECRYPT);
        end
    end

    assign ra = pa_reg[2*CoordW-1:CoordW];
    assign ca = pa_reg[CoordW-1:0];
    assign rb = pb_reg[2*CoordW-1:CoordW];
    assign cb = pb_reg[CoordW-1:0];

    always_comb begin
        priority if (ra == rb && ca == cb) begin
            ra_o = ra;                   ca_o = ca;
            rb_o = ra;                   cb_o = ca;
        end else if (ra == rb) begin
            ra_o = ra;                   ca_o = step_mod5(ca, back_reg);
            rb_o = rb;                   cb_o = step_mod5(cb, back_reg);
        end else if (ca == cb) begin
            ra_o = step_mod5(ra, back_reg); ca_o = ca;
            rb_o = step_mod5(rb, back_reg); cb_o = cb;
        end else begin
            ra_o = ra;                   ca_o = cb;
            rb_o = rb;                   cb_o = ca;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cell_load) begin
            if (ready_reg) begin
                first_reg  <= sq_mem[cell_index(ra_o, ca_o)];
                second_reg <= sq_mem[cell_index(rb_o, cb_o)];
                nr_reg     <= 1'b0;
            end else begin
                first_reg  <= '0;
                second_reg <= '0;
                nr_reg     <= 1'b1;
            end
        end
    end

    assign first_letter  = first_reg;
    assign second_letter = second_reg;
    assign not_ready     = nr_reg;

endmodule

// ----- hdl/playfair_digraph_cipher_top.sv -----
// top level of the playfair digraph cipher: controller plus datapath
`timescale 1ns / 1ps
//
//  channel   direction  tdata (low bit up)                tuser
//  s_        in         letter_a[4:0], letter_b[9:5]      kind[1:0]
//  m_        out        first_letter[4:0], second[9:5]    not_ready[0]
//
// a key letter is placed at its accept edge
// a key end runs one fill step per letter, up to 26, after its accept;
//   the fill walks the letters a..z one per cycle through the square write port
// a pair runs a position memory read, then a square read into the result
// reset clears the used-letter mask, fill pointer and ready flag; memories are
//   not cleared, a pair before key end returns zeros with not_ready set
// a stalled result holds in the output register; the next item is still taken,
//   a following pair waits in the square read step until the slot frees

module playfair_digraph_cipher_top
    import pfdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // letter_a[4:0], letter_b[9:5], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // first_letter[4:0], second_letter[9:5], zero pad
    output logic [0:0]  m_tuser    // not_ready[0]
);

    dp_cmd_t            cmd;
    dp_status_t         status;
    kind_t              s_kind;
    logic [LetterW-1:0] first_letter, second_letter;
    logic               not_ready;

    // kind selects the operation of the input transaction
    assign s_kind = kind_t'(s_tuser);

    pfdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_kind),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pfdc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_kind        (s_kind),
        .s_letter_a    (s_tdata[4:0]),
        .s_letter_b    (s_tdata[9:5]),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .not_ready     (not_ready)
    );

    // result transaction packing
    assign m_tdata = {6'd0, second_letter, first_letter};
    assign m_tuser = not_ready;

endmodule

// ----- hdl/pfdc_checker.sv -----
// port-level checker of the playfair digraph cipher, bound to the top level
`timescale 1ns / 1ps

module pfdc_checker
    import pfdc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a result before key end carries no letters
    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("not ready result with nonzero letters");

    // the square never holds j or a code above z
    a_letters_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[4:0] <= LETTER_Z && m_tdata[9:5] <= LETTER_Z
            && m_tdata[4:0] != LETTER_J && m_tdata[9:5] != LETTER_J
            && m_tdata[15:10] == 6'd0)
        else $error("result letter out of square alphabet");

    // key end and pair transactions move the block out of idle, so the input drops ready after their accept
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != KIND_KEY_LETTER) |=> !s_tready)
        else $error("input taken during fill or square read");

endmodule

bind playfair_digraph_cipher_top pfdc_checker u_pfdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
